>>> src/srdz_pkg.sv
// shared constants, types and codes for the scaled radial dead zone core
package srdz_pkg;

   localparam int SAMPLE_WIDTH = 16;
   localparam int FRAC_BITS    = SAMPLE_WIDTH - 2;
   localparam int LIMIT_WIDTH  = SAMPLE_WIDTH - 1;
   localparam int MAG_WIDTH    = SAMPLE_WIDTH;
   localparam int SUM_WIDTH    = 2 * SAMPLE_WIDTH;
   localparam int PROD_WIDTH   = SAMPLE_WIDTH + FRAC_BITS;
   localparam int QUO_WIDTH    = FRAC_BITS + 1;

   localparam logic [LIMIT_WIDTH-1:0] FX_ONE = LIMIT_WIDTH'(1) << FRAC_BITS;

   localparam logic [1:0] OP_SCALAR = 2'd0;
   localparam logic [1:0] OP_VEC2   = 2'd1;
   localparam logic [1:0] OP_VEC3   = 2'd2;
   localparam logic [1:0] OP_PASS   = 2'd3;

   localparam logic [0:0] CSR_INNER = 1'd0;
   localparam logic [0:0] CSR_OUTER = 1'd1;

   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_AW    = 2;

   // back pipeline stage map
   localparam int ROOT_STEPS = MAG_WIDTH;
   localparam int ROOT_LAST  = ROOT_STEPS;
   localparam int SETUP_ST   = ROOT_LAST + 1;
   localparam int SDIV_FIRST = SETUP_ST + 1;
   localparam int SDIV_LAST  = SETUP_ST + FRAC_BITS;
   localparam int MULT_ST    = SDIV_LAST + 1;
   localparam int LDIV_FIRST = MULT_ST + 1;
   localparam int LDIV_LAST  = MULT_ST + QUO_WIDTH;
   localparam int LAST_ST    = LDIV_LAST;

   typedef struct packed {
      logic [LIMIT_WIDTH-1:0] inner;
      logic [LIMIT_WIDTH-1:0] outer;
   } srdz_cfg_type;

   typedef struct packed {
      logic [1:0]              op;
      logic [SAMPLE_WIDTH-1:0] x;
      logic [SAMPLE_WIDTH-1:0] y;
      logic [SAMPLE_WIDTH-1:0] z;
      logic [SAMPLE_WIDTH-1:0] ax;
      logic [SAMPLE_WIDTH-1:0] ay;
      logic [SAMPLE_WIDTH-1:0] az;
      logic [SUM_WIDTH-1:0]    sum;
   } srdz_item_type;

   typedef struct packed {
      logic [MAG_WIDTH:0]    rem;
      logic [QUO_WIDTH-1:0]  dvd;
      logic [QUO_WIDTH-1:0]  q;
   } srdz_lane_type;

   typedef struct packed {
      logic [1:0]              op;
      logic [SAMPLE_WIDTH-1:0] x;
      logic [SAMPLE_WIDTH-1:0] y;
      logic [SAMPLE_WIDTH-1:0] z;
      logic [SAMPLE_WIDTH-1:0] ax;
      logic [SAMPLE_WIDTH-1:0] ay;
      logic [SAMPLE_WIDTH-1:0] az;
      logic [SUM_WIDTH-1:0]    rem;
      logic [SUM_WIDTH-1:0]    root;
      logic [MAG_WIDTH-1:0]    mag;
      logic                    zero;
      logic                    sat;
      logic [LIMIT_WIDTH-1:0]  den;
      logic [MAG_WIDTH-1:0]    drem;
      logic [FRAC_BITS-1:0]    q;
      srdz_lane_type           lx;
      srdz_lane_type           ly;
      srdz_lane_type           lz;
   } srdz_work_type;

endpackage

>>> src/srdz_req_if.sv
// input channel: sample kind and three components
interface srdz_req_if import srdz_pkg::*;;
   logic                           valid;
   logic                           ready;
   logic [1:0]                     operation;
   logic signed [SAMPLE_WIDTH-1:0] in_x;
   logic signed [SAMPLE_WIDTH-1:0] in_y;
   logic signed [SAMPLE_WIDTH-1:0] in_z;

   modport source (output valid, operation, in_x, in_y, in_z, input ready);
   modport sink (input valid, operation, in_x, in_y, in_z, output ready);
endinterface

>>> src/srdz_rsp_if.sv
// result channel: three conditioned components
interface srdz_rsp_if import srdz_pkg::*;;
   logic                           valid;
   logic                           ready;
   logic signed [SAMPLE_WIDTH-1:0] out_x;
   logic signed [SAMPLE_WIDTH-1:0] out_y;
   logic signed [SAMPLE_WIDTH-1:0] out_z;

   modport source (output valid, out_x, out_y, out_z, input ready);
   modport sink (input valid, out_x, out_y, out_z, output ready);
endinterface

>>> src/srdz_front.sv
// front end: accepts items, takes magnitudes and sums the squares
module srdz_front import srdz_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   srdz_req_if.sink      req_chan,
   output logic          push_valid,
   output srdz_item_type push_data,
   input  logic          queue_full
);

   logic                 s1_v_ff, s2_v_ff;
   srdz_item_type        s1_ff, s1_in, s2_ff;
   logic [SUM_WIDTH-1:0] sq_x_ff, sq_y_ff, sq_z_ff;
   logic                 en;

   assign en = !s2_v_ff || !queue_full;
   assign req_chan.ready = en;

   always_comb begin
      s1_in.op  = req_chan.operation;
      s1_in.x   = req_chan.in_x;
      s1_in.y   = req_chan.in_y;
      s1_in.z   = req_chan.in_z;
      s1_in.ax  = req_chan.in_x[SAMPLE_WIDTH-1] ? SAMPLE_WIDTH'(-req_chan.in_x) : req_chan.in_x;
      s1_in.ay  = req_chan.in_y[SAMPLE_WIDTH-1] ? SAMPLE_WIDTH'(-req_chan.in_y) : req_chan.in_y;
      s1_in.az  = req_chan.in_z[SAMPLE_WIDTH-1] ? SAMPLE_WIDTH'(-req_chan.in_z) : req_chan.in_z;
      s1_in.sum = '0;
      // unused components drop out of the magnitude
      if (req_chan.operation == OP_SCALAR) begin
         s1_in.ay = '0;
      end
      if (req_chan.operation != OP_VEC3) begin
         s1_in.az = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff <= 1'b0;
         s2_v_ff <= 1'b0;
      end else if (en) begin
         s1_v_ff <= req_chan.valid;
         s2_v_ff <= s1_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s1_ff   <= s1_in;
         s2_ff   <= s1_ff;
         sq_x_ff <= s1_ff.ax * s1_ff.ax;
         sq_y_ff <= s1_ff.ay * s1_ff.ay;
         sq_z_ff <= s1_ff.az * s1_ff.az;
      end
   end

   always_comb begin
      push_data     = s2_ff;
      push_data.sum = sq_x_ff + sq_y_ff + sq_z_ff;
   end

   assign push_valid = s2_v_ff;

endmodule

>>> src/srdz_queue.sv
// short item queue between front and back
module srdz_queue import srdz_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          push_valid,
   input  srdz_item_type push_data,
   output logic          full,
   input  logic          pop,
   output srdz_item_type pop_data,
   output logic          empty
);

   srdz_item_type         mem_ff [QUEUE_DEPTH];
   logic [QUEUE_AW-1:0]   wr_ff, rd_ff;
   logic [QUEUE_AW:0]     count_ff;
   logic                  do_push, do_pop;

   assign full     = count_ff == (QUEUE_AW + 1)'(QUEUE_DEPTH);
   assign empty    = count_ff == '0;
   assign do_push  = push_valid && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = mem_ff[rd_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         if (do_push) begin
            wr_ff <= wr_ff + 1'b1;
         end
         if (do_pop) begin
            rd_ff <= rd_ff + 1'b1;
         end
         if (do_push && !do_pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (do_pop && !do_push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ff] <= push_data;
      end
   end

endmodule

>>> src/srdz_back.sv
// back end: root, scale division, per-component division and output register
module srdz_back import srdz_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  srdz_cfg_type  cfg,
   input  srdz_item_type pop_data,
   input  logic          queue_empty,
   output logic          pop,
   srdz_rsp_if.source    rsp_chan
);

   srdz_work_type stage_ff [LAST_ST+1];
   srdz_work_type stage_in [LAST_ST+1];
   logic          valid_ff [LAST_ST+1];
   logic          out_v_ff;
   logic [SAMPLE_WIDTH-1:0] out_x_ff, out_y_ff, out_z_ff, out_x_in, out_y_in, out_z_in;
   logic          en;

   function automatic srdz_work_type root_step(srdz_work_type w, int j);
      srdz_work_type        r;
      logic [SUM_WIDTH-1:0] bitv;
      logic [SUM_WIDTH:0]   t;
      r    = w;
      bitv = (SUM_WIDTH'(1) << (SUM_WIDTH - 2)) >> (2 * j);
      t    = {1'b0, w.root} + {1'b0, bitv};
      if ({1'b0, w.rem} >= t) begin
         r.rem  = w.rem - t[SUM_WIDTH-1:0];
         r.root = (w.root >> 1) + bitv;
      end else begin
         r.root = w.root >> 1;
      end
      return r;
   endfunction

   function automatic srdz_work_type setup_step(srdz_work_type w, srdz_cfg_type c);
      srdz_work_type        r;
      logic [MAG_WIDTH-1:0] m, diff;
      r      = w;
      m      = w.root[MAG_WIDTH-1:0];
      diff   = m - {1'b0, c.inner};
      r.mag  = m;
      r.zero = (m < {1'b0, c.inner}) || (m == '0);
      r.den  = c.outer - c.inner;
      r.sat  = (c.outer <= c.inner) || (diff >= {1'b0, r.den});
      r.drem = diff;
      r.q    = '0;
      return r;
   endfunction

   function automatic srdz_work_type sdiv_step(srdz_work_type w);
      srdz_work_type        r;
      logic [MAG_WIDTH-1:0] t;
      r = w;
      t = {w.drem[MAG_WIDTH-2:0], 1'b0};
      if (t >= {1'b0, w.den}) begin
         r.drem = t - {1'b0, w.den};
         r.q    = {w.q[FRAC_BITS-2:0], 1'b1};
      end else begin
         r.drem = t;
         r.q    = {w.q[FRAC_BITS-2:0], 1'b0};
      end
      return r;
   endfunction

   function automatic srdz_lane_type lane_init(logic [SAMPLE_WIDTH-1:0] a,
                                               logic [LIMIT_WIDTH-1:0] s);
      srdz_lane_type       l;
      logic [PROD_WIDTH:0] p;
      p     = a * s;
      l.rem = (MAG_WIDTH + 1)'(p[PROD_WIDTH-1:QUO_WIDTH]);
      l.dvd = p[QUO_WIDTH-1:0];
      l.q   = '0;
      return l;
   endfunction

   function automatic srdz_work_type mult_step(srdz_work_type w);
      srdz_work_type          r;
      logic [LIMIT_WIDTH-1:0] s;
      r    = w;
      s    = w.sat ? FX_ONE : {1'b0, w.q};
      r.lx = lane_init(w.ax, s);
      r.ly = lane_init(w.ay, s);
      r.lz = lane_init(w.az, s);
      return r;
   endfunction

   function automatic srdz_lane_type lane_step(srdz_lane_type l, logic [MAG_WIDTH-1:0] m);
      srdz_lane_type      r;
      logic [MAG_WIDTH:0] t;
      t     = {l.rem[MAG_WIDTH-1:0], l.dvd[QUO_WIDTH-1]};
      r.dvd = {l.dvd[QUO_WIDTH-2:0], 1'b0};
      if (t >= {1'b0, m}) begin
         r.rem = t - {1'b0, m};
         r.q   = {l.q[QUO_WIDTH-2:0], 1'b1};
      end else begin
         r.rem = t;
         r.q   = {l.q[QUO_WIDTH-2:0], 1'b0};
      end
      return r;
   endfunction

   function automatic srdz_work_type ldiv_step(srdz_work_type w);
      srdz_work_type r;
      r    = w;
      r.lx = lane_step(w.lx, w.mag);
      r.ly = lane_step(w.ly, w.mag);
      r.lz = lane_step(w.lz, w.mag);
      return r;
   endfunction

   function automatic logic [SAMPLE_WIDTH-1:0] signed_q(logic neg, logic [QUO_WIDTH-1:0] q);
      logic [SAMPLE_WIDTH-1:0] v;
      v = SAMPLE_WIDTH'(q);
      return neg ? SAMPLE_WIDTH'(-v) : v;
   endfunction

   assign en  = !out_v_ff || rsp_chan.ready;
   assign pop = en && !queue_empty;

   always_comb begin
      stage_in[0]      = '0;
      stage_in[0].op   = pop_data.op;
      stage_in[0].x    = pop_data.x;
      stage_in[0].y    = pop_data.y;
      stage_in[0].z    = pop_data.z;
      stage_in[0].ax   = pop_data.ax;
      stage_in[0].ay   = pop_data.ay;
      stage_in[0].az   = pop_data.az;
      stage_in[0].rem  = pop_data.sum;
   end

   for (genvar k = 1; k <= LAST_ST; k++) begin : g_stage
      if (k <= ROOT_LAST) begin : g_root
         assign stage_in[k] = root_step(stage_ff[k-1], k - 1);
      end else if (k == SETUP_ST) begin : g_setup
         assign stage_in[k] = setup_step(stage_ff[k-1], cfg);
      end else if (k <= SDIV_LAST) begin : g_sdiv
         assign stage_in[k] = sdiv_step(stage_ff[k-1]);
      end else if (k == MULT_ST) begin : g_mult
         assign stage_in[k] = mult_step(stage_ff[k-1]);
      end else begin : g_ldiv
         assign stage_in[k] = ldiv_step(stage_ff[k-1]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i <= LAST_ST; i++) begin
            valid_ff[i] <= 1'b0;
         end
         out_v_ff <= 1'b0;
      end else if (en) begin
         valid_ff[0] <= !queue_empty;
         for (int i = 1; i <= LAST_ST; i++) begin
            valid_ff[i] <= valid_ff[i-1];
         end
         out_v_ff <= valid_ff[LAST_ST];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i <= LAST_ST; i++) begin
            stage_ff[i] <= stage_in[i];
         end
         out_x_ff <= out_x_in;
         out_y_ff <= out_y_in;
         out_z_ff <= out_z_in;
      end
   end

   always_comb begin
      out_x_in = '0;
      out_y_in = '0;
      out_z_in = '0;
      if (stage_ff[LAST_ST].op == OP_PASS) begin
         out_x_in = stage_ff[LAST_ST].x;
         out_y_in = stage_ff[LAST_ST].y;
         out_z_in = stage_ff[LAST_ST].z;
      end else if (!stage_ff[LAST_ST].zero) begin
         out_x_in = signed_q(stage_ff[LAST_ST].x[SAMPLE_WIDTH-1], stage_ff[LAST_ST].lx.q);
         if (stage_ff[LAST_ST].op != OP_SCALAR) begin
            out_y_in = signed_q(stage_ff[LAST_ST].y[SAMPLE_WIDTH-1], stage_ff[LAST_ST].ly.q);
         end
         if (stage_ff[LAST_ST].op == OP_VEC3) begin
            out_z_in = signed_q(stage_ff[LAST_ST].z[SAMPLE_WIDTH-1], stage_ff[LAST_ST].lz.q);
         end
      end
   end

   assign rsp_chan.valid = out_v_ff;
   assign rsp_chan.out_x = out_x_ff;
   assign rsp_chan.out_y = out_y_ff;
   assign rsp_chan.out_z = out_z_ff;

endmodule

>>> src/scaled_radial_dead_zone_core.sv
// throughput: one item per cycle unless stalled; the front stages, a four-item
// queue and a 48-stage back pipeline (16 root steps, 14 scale-division steps,
// 15 component division steps); the front stages hold while the queue is full
// and the back pipeline holds while its result is not taken by the sink
// reset: synchronous, clears valid flags and queue count; inner limit 0, outer 1.0
module scaled_radial_dead_zone_core import srdz_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   srdz_req_if.sink               req_chan,
   srdz_rsp_if.source             rsp_chan,
   input  logic                   csr_write_enable,
   input  logic [0:0]             csr_index,
   input  logic [LIMIT_WIDTH-1:0] csr_write_data
);

   srdz_cfg_type  cfg_ff;
   srdz_item_type push_data, pop_data;
   logic          push_valid, queue_full, queue_empty, pop;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.inner <= '0;
         cfg_ff.outer <= FX_ONE;
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_INNER: cfg_ff.inner <= csr_write_data;
            CSR_OUTER: cfg_ff.outer <= csr_write_data;
            default: ;
         endcase
      end
   end

   srdz_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_chan   (req_chan),
      .push_valid (push_valid),
      .push_data  (push_data),
      .queue_full (queue_full)
   );

   srdz_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_data  (push_data),
      .full       (queue_full),
      .pop        (pop),
      .pop_data   (pop_data),
      .empty      (queue_empty)
   );

   srdz_back u_back (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg_ff),
      .pop_data    (pop_data),
      .queue_empty (queue_empty),
      .pop         (pop),
      .rsp_chan    (rsp_chan)
   );

endmodule

>>> verif/testbench.sv
// self-checking testbench for the scaled radial dead zone core
module testbench import srdz_pkg::*;;
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct {
      logic [1:0]                     op;
      logic signed [SAMPLE_WIDTH-1:0] x;
      logic signed [SAMPLE_WIDTH-1:0] y;
      logic signed [SAMPLE_WIDTH-1:0] z;
   } sample_type;

   typedef struct {
      logic signed [SAMPLE_WIDTH-1:0] x;
      logic signed [SAMPLE_WIDTH-1:0] y;
      logic signed [SAMPLE_WIDTH-1:0] z;
   } cond_type;

   localparam int STALL_LIMIT = 4000;
   localparam int DRAIN_CYCLES = 120;

   logic clock;
   logic reset;
   logic csr_write_enable;
   logic [0:0] csr_index;
   logic [LIMIT_WIDTH-1:0] csr_write_data;

   srdz_req_if req_chan ();
   srdz_rsp_if rsp_chan ();

   scaled_radial_dead_zone_core uut (
      .clock(clock),
      .reset(reset),
      .req_chan(req_chan.sink),
      .rsp_chan(rsp_chan.source),
      .csr_write_enable(csr_write_enable),
      .csr_index(csr_index),
      .csr_write_data(csr_write_data)
   );

   sample_type pending_samples[$];
   cond_type expected_outputs[$];
   longint unsigned inner_lim;
   longint unsigned outer_lim;
   int error_count;
   int idle_cycles;
   bit steady;
   bit stim_done;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic longint unsigned isqrt(longint unsigned v);
      longint unsigned r;
      longint unsigned b;
      r = 0;
      b = 64'd1 << 62;
      while (b > v) b = b >> 2;
      while (b != 0) begin
         if (v >= r + b) begin
            v = v - (r + b);
            r = (r >> 1) + b;
         end else begin
            r = r >> 1;
         end
         b = b >> 2;
      end
      return r;
   endfunction

   function automatic logic signed [SAMPLE_WIDTH-1:0] scale_comp(longint c,
         longint unsigned scale, longint unsigned mag);
      longint unsigned a;
      longint unsigned q;
      a = (c < 0) ? -c : c;
      q = (a * scale) / mag;
      if (c < 0) q = -q;
      return q[SAMPLE_WIDTH-1:0];
   endfunction

   function automatic cond_type condition_sample(sample_type s);
      cond_type r;
      longint c[3];
      longint unsigned sum;
      longint unsigned mag;
      longint unsigned scale;
      int n;
      r.x = '0;
      r.y = '0;
      r.z = '0;
      if (s.op == OP_PASS) begin
         r.x = s.x;
         r.y = s.y;
         r.z = s.z;
         return r;
      end
      c[0] = s.x;
      c[1] = s.y;
      c[2] = s.z;
      n = int'(s.op) + 1;
      sum = 0;
      for (int i = 0; i < n; i++) sum += c[i] * c[i];
      mag = isqrt(sum);
      if (mag < inner_lim || mag == 0) return r;
      if (outer_lim <= inner_lim) begin
         scale = FX_ONE;
      end else begin
         scale = ((mag - inner_lim) << FRAC_BITS) / (outer_lim - inner_lim);
         if (scale > FX_ONE) scale = FX_ONE;
      end
      r.x = scale_comp(c[0], scale, mag);
      if (n > 1) r.y = scale_comp(c[1], scale, mag);
      if (n > 2) r.z = scale_comp(c[2], scale, mag);
      return r;
   endfunction

   function automatic logic signed [SAMPLE_WIDTH-1:0] rand_comp();
      case ($urandom_range(0, 5))
         0: return $urandom_range(0, 1) ? 16'sh8000 : 16'sh7fff;
         1: return $signed(16'($urandom_range(0, 32))) - 16'sd16;
         2: return $urandom_range(0, 1) ? 16'sd16384 : -16'sd16384;
         3, 4: return $signed(16'($urandom_range(0, 32768))) - 16'sd16384;
         default: return 16'($urandom);
      endcase
   endfunction

   task automatic add_sample(logic [1:0] op, logic signed [SAMPLE_WIDTH-1:0] x,
         logic signed [SAMPLE_WIDTH-1:0] y, logic signed [SAMPLE_WIDTH-1:0] z);
      sample_type s;
      s.op = op;
      s.x = x;
      s.y = y;
      s.z = z;
      pending_samples.push_back(s);
   endtask

   // only called when the pipeline is empty
   task automatic write_limits(longint unsigned inner_v, longint unsigned outer_v);
      @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_index <= CSR_INNER;
      csr_write_data <= inner_v[LIMIT_WIDTH-1:0];
      @(posedge clock);
      csr_index <= CSR_OUTER;
      csr_write_data <= outer_v[LIMIT_WIDTH-1:0];
      @(posedge clock);
      csr_write_enable <= 1'b0;
      inner_lim = inner_v[LIMIT_WIDTH-1:0];
      outer_lim = outer_v[LIMIT_WIDTH-1:0];
   endtask

   task automatic wait_drained();
      while (pending_samples.size() != 0 || expected_outputs.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_chan.valid <= 1'b0;
      end else begin
         if (req_chan.valid && req_chan.ready) begin
            expected_outputs.push_back(condition_sample(pending_samples.pop_front()));
         end
         if (!req_chan.valid || req_chan.ready) begin
            if (pending_samples.size() > 0 &&
                (steady || $urandom_range(0, 99) >= 23)) begin
               req_chan.valid <= 1'b1;
               req_chan.operation <= pending_samples[0].op;
               req_chan.in_x <= pending_samples[0].x;
               req_chan.in_y <= pending_samples[0].y;
               req_chan.in_z <= pending_samples[0].z;
            end else begin
               req_chan.valid <= 1'b0;
            end
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      cond_type e;
      if (reset) begin
         rsp_chan.ready <= 1'b0;
         idle_cycles <= 0;
      end else begin
         rsp_chan.ready <= steady || $urandom_range(0, 99) >= 23;
         if (rsp_chan.valid && rsp_chan.ready) begin
            if (expected_outputs.size() == 0) begin
               $error("unexpected item: out_x %0d", rsp_chan.out_x);
               error_count++;
            end else begin
               e = expected_outputs.pop_front();
               if (rsp_chan.out_x !== e.x) begin
                  $error("out_x expected %0d actual %0d", e.x, rsp_chan.out_x);
                  error_count++;
               end
               if (rsp_chan.out_y !== e.y) begin
                  $error("out_y expected %0d actual %0d", e.y, rsp_chan.out_y);
                  error_count++;
               end
               if (rsp_chan.out_z !== e.z) begin
                  $error("out_z expected %0d actual %0d", e.z, rsp_chan.out_z);
                  error_count++;
               end
            end
         end
         if ((rsp_chan.valid && rsp_chan.ready) || (req_chan.valid && req_chan.ready) ||
             (pending_samples.size() == 0 && expected_outputs.size() == 0))
            idle_cycles <= 0;
         else
            idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= STALL_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
         end
      end
   end

   initial begin
      longint unsigned settings[8][2];
      logic [1:0] op;
      reset = 1'b1;
      error_count = 0;
      steady = 1'b0;
      csr_write_enable = 1'b0;
      csr_index = CSR_INNER;
      csr_write_data = '0;
      req_chan.valid = 1'b0;
      req_chan.operation = OP_SCALAR;
      req_chan.in_x = '0;
      req_chan.in_y = '0;
      req_chan.in_z = '0;
      rsp_chan.ready = 1'b0;
      inner_lim = 0;
      outer_lim = FX_ONE;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // directed items at reset limits
      add_sample(OP_SCALAR, 16'sh7fff, 0, 0);
      add_sample(OP_SCALAR, 16'sh8000, 16'sh1234, 16'sh4321);
      add_sample(OP_SCALAR, 0, 0, 0);
      add_sample(OP_SCALAR, -16'sd1, 0, 0);
      add_sample(OP_VEC2, 16'sh8000, 16'sh8000, 16'sh7fff);
      add_sample(OP_VEC2, 16'sh7fff, 16'sh7fff, 0);
      add_sample(OP_VEC2, 0, 0, 16'sh5555);
      add_sample(OP_VEC2, 16'sd3000, -16'sd4000, 0);
      add_sample(OP_VEC3, 16'sh8000, 16'sh8000, 16'sh8000);
      add_sample(OP_VEC3, 16'sh7fff, -16'sd1, 16'sh7fff);
      add_sample(OP_VEC3, 0, 0, 0);
      add_sample(OP_VEC3, 16'sd100, 16'sd200, -16'sd300);
      add_sample(OP_PASS, 16'sh8000, 16'sh7fff, -16'sd1);
      add_sample(OP_PASS, 0, 16'sh5555, 16'shaaaa);
      wait_drained();

      // inner above outer gives pure direction; also out-of-range limits
      write_limits(16'd8000, 16'd4000);
      add_sample(OP_SCALAR, 16'sd9000, 0, 0);
      add_sample(OP_SCALAR, 16'sd7999, 0, 0);
      add_sample(OP_VEC2, 16'sd6000, -16'sd6000, 0);
      add_sample(OP_VEC3, -16'sd5000, 16'sd5000, 16'sd5000);
      wait_drained();
      write_limits(16'h7fff, 16'h7fff);
      add_sample(OP_VEC3, 16'sh8000, 16'sh8000, 16'sh8000);
      add_sample(OP_SCALAR, 16'sh8000, 0, 0);
      add_sample(OP_SCALAR, 16'sh7fff, 0, 0);
      wait_drained();

      settings[0] = '{0, FX_ONE};
      settings[1] = '{FX_ONE, 0};
      settings[2] = '{2000, 14000};
      settings[3] = '{0, 0};
      settings[4] = '{16'h7fff, 0};
      settings[5] = '{100, 16'h7fff};
      settings[6] = '{FX_ONE, FX_ONE};
      settings[7] = '{4096, 4097};
      for (int p = 0; p < 8; p++) begin
         write_limits(settings[p][0], settings[p][1]);
         steady = (p == 3);
         for (int i = 0; i < 135; i++) begin
            op = 2'($urandom_range(0, 3));
            add_sample(op, rand_comp(), rand_comp(), rand_comp());
         end
         wait_drained();
      end
      for (int i = 0; i < 60; i++) begin
         write_limits($urandom_range(0, 16384), $urandom_range(0, 16384));
         add_sample(2'($urandom_range(0, 3)), rand_comp(), rand_comp(), rand_comp());
         wait_drained();
      end

      if (error_count == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end
endmodule

>>> sim.f
src/srdz_pkg.sv
src/srdz_req_if.sv
src/srdz_rsp_if.sv
src/srdz_front.sv
src/srdz_queue.sv
src/srdz_back.sv
src/scaled_radial_dead_zone_core.sv
verif/testbench.sv
